FILE: rtl/core/lkvc_pkg.sv
// lkvc_pkg: sizes, command codes and item types of the lru key/value cache
// used by lru_key_value_cache; depends on nothing
`timescale 1ns / 1ps

package lkvc_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int KEY_BITS    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int CAP_BITS    = 5;
   localparam int CAP_RESET   = 16;

   localparam int AGE_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_STORE  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                       command;
      logic        [KEY_BITS-1:0]    lookup_key;
      logic signed [VALUE_BITS-1:0]  store_value;
   } req_item_type;

   typedef struct packed {
      logic                          found;
      logic signed [VALUE_BITS-1:0]  read_value;
      logic                          evicted;
      logic        [KEY_BITS-1:0]    evicted_key;
   } rsp_item_type;

endpackage

FILE: rtl/core/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key/value store with lru replacement
// depends on lkvc_pkg for sizes, command codes and item types
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------------
// req      | in        | req_valid / req_stall | req_item (command, key, value)
// rsp      | out       | rsp_valid / rsp_stall | rsp_item (found, value, evicted)
// csr      | in        | csr_valid / csr_ready | csr_data (active capacity)
//
// two register stages: an accepted item sits in the input register while the
// tag compare, age update and slot choice run, then its result lands in the
// output register; one item per cycle while the result is not stalled
// the entry state updates at the same edge the result is loaded, so the next
// item always sees the state left by the one before it
// synchronous reset clears the valid marks, ages and fill count; no sweep
// a stalled result holds the output register and back-pressures the input
// register only when both are full

module lru_key_value_cache (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  lkvc_pkg::req_item_type req_item,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lkvc_pkg::rsp_item_type rsp_item,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_data
);

   localparam int N = lkvc_pkg::MAX_ENTRIES;

   // capacity register
   logic [lkvc_pkg::CAP_BITS-1:0] cap_ff;

   // input stage
   logic                   in_valid_ff;
   lkvc_pkg::req_item_type in_item_ff;

   // output stage
   logic                   rsp_valid_ff;
   lkvc_pkg::rsp_item_type rsp_item_ff;
   lkvc_pkg::rsp_item_type rsp_item_in;

   // entry state
   logic [N-1:0]                           valid_ff;
   logic [N-1:0]                           valid_in;
   logic [lkvc_pkg::KEY_BITS-1:0]          key_ff   [N];
   logic [lkvc_pkg::VALUE_BITS-1:0]        value_ff [N];
   logic [lkvc_pkg::AGE_BITS-1:0]          age_ff   [N];
   logic [lkvc_pkg::AGE_BITS-1:0]          age_in   [N];
   logic [lkvc_pkg::COUNT_BITS-1:0]        used_count_ff;
   logic [lkvc_pkg::COUNT_BITS-1:0]        used_count_in;

   // datapath
   logic                                   advance;
   logic                                   req_accept;
   logic [N-1:0]                           match_vec;
   logic [N-1:0]                           oldest_vec;
   logic [N-1:0]                           evict_vec;
   logic [N-1:0]                           free_vec;
   logic [N-1:0]                           insert_vec;
   logic [N-1:0]                           write_vec;
   logic                                   hit;
   logic                                   is_store;
   logic                                   do_insert;
   logic                                   do_evict;
   logic                                   at_capacity;
   logic [lkvc_pkg::AGE_BITS-1:0]          hit_age;
   logic [lkvc_pkg::AGE_BITS-1:0]          oldest_age;
   logic [lkvc_pkg::VALUE_BITS-1:0]        hit_value;
   logic [lkvc_pkg::KEY_BITS-1:0]          victim_key;
   logic [lkvc_pkg::CMP_BITS-1:0]          cap_ext;
   logic [lkvc_pkg::CMP_BITS-1:0]          cap_eff;
   logic [lkvc_pkg::CMP_BITS-1:0]          used_ext;

   // handshakes: the input register moves on when the output register is empty or not stalled
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign csr_ready  = 1'b1;

   // effective capacity: zero acts as one, clipped to the entry count
   always_comb begin
      cap_ext  = lkvc_pkg::CMP_BITS'(cap_ff);
      used_ext = lkvc_pkg::CMP_BITS'(used_count_ff);
      if (cap_ext == '0) begin
         cap_eff = lkvc_pkg::CMP_BITS'(1);
      end else if (cap_ext > lkvc_pkg::CMP_BITS'(N)) begin
         cap_eff = lkvc_pkg::CMP_BITS'(N);
      end else begin
         cap_eff = cap_ext;
      end
      at_capacity = (used_ext >= cap_eff) || (used_ext >= lkvc_pkg::CMP_BITS'(N));
   end

   // tag compare and one-hot selects; valid ages are 0 .. used_count-1,
   // so the least recent entry is the one whose age is used_count-1
   always_comb begin
      oldest_age = lkvc_pkg::AGE_BITS'(used_count_ff - lkvc_pkg::COUNT_BITS'(1));
      hit_age    = '0;
      hit_value  = '0;
      for (int i = 0; i < N; i++) begin
         match_vec[i]  = valid_ff[i] && (key_ff[i] == in_item_ff.lookup_key);
         oldest_vec[i] = valid_ff[i] && (age_ff[i] == oldest_age);
         hit_age       = hit_age | (age_ff[i] & {lkvc_pkg::AGE_BITS{match_vec[i]}});
         hit_value     = hit_value | (value_ff[i] & {lkvc_pkg::VALUE_BITS{match_vec[i]}});
      end
      hit       = |match_vec;
      is_store  = (in_item_ff.command == lkvc_pkg::CMD_STORE);
      do_insert = is_store && !hit;
      do_evict  = do_insert && at_capacity;
      evict_vec = do_evict ? oldest_vec : '0;

      victim_key = '0;
      for (int i = 0; i < N; i++) begin
         victim_key = victim_key | (key_ff[i] & {lkvc_pkg::KEY_BITS{evict_vec[i]}});
      end

      // lowest free slot once the victim is gone
      free_vec   = ~(valid_ff & ~evict_vec);
      insert_vec = do_insert ? (free_vec & (~free_vec + {{(N-1){1'b0}}, 1'b1})) : '0;
      write_vec  = insert_vec | (is_store ? match_vec : '0);
   end

   // next entry state
   always_comb begin
      valid_in      = valid_ff;
      used_count_in = used_count_ff;
      for (int i = 0; i < N; i++) begin
         age_in[i] = age_ff[i];
      end
      if (hit) begin
         // touch: entries younger than the hit age by one
         for (int i = 0; i < N; i++) begin
            if (match_vec[i]) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
               age_in[i] = age_ff[i] + lkvc_pkg::AGE_BITS'(1);
            end
         end
      end else if (do_insert) begin
         // every surviving entry ages, the new one is most recent
         for (int i = 0; i < N; i++) begin
            if (insert_vec[i]) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && !evict_vec[i]) begin
               age_in[i] = age_ff[i] + lkvc_pkg::AGE_BITS'(1);
            end
         end
         valid_in = (valid_ff & ~evict_vec) | insert_vec;
         if (!do_evict) begin
            used_count_in = used_count_ff + lkvc_pkg::COUNT_BITS'(1);
         end
      end
   end

   // result item
   always_comb begin
      rsp_item_in.found       = hit;
      rsp_item_in.read_value  = (hit && !is_store) ? hit_value : '0;
      rsp_item_in.evicted     = do_evict;
      rsp_item_in.evicted_key = victim_key;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= lkvc_pkg::CAP_BITS'(lkvc_pkg::CAP_RESET);
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         used_count_ff <= '0;
         for (int i = 0; i < N; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (!in_valid_ff || advance) begin
            in_valid_ff <= req_accept;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            valid_ff      <= valid_in;
            used_count_ff <= used_count_in;
            for (int i = 0; i < N; i++) begin
               age_ff[i] <= age_in[i];
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
         for (int i = 0; i < N; i++) begin
            if (write_vec[i]) begin
               key_ff[i]   <= in_item_ff.lookup_key;
               value_ff[i] <= in_item_ff.store_value;
            end
         end
      end
   end

endmodule
